// ===== sv/spcd_pkg.sv =====
// Shared types and constants for the sensor port connect detector.
package spcd_pkg;

   // Connection state machine, one-hot.
   typedef enum logic [7:0] {
      ST_INIT     = 8'b0000_0001,
      ST_SETTLE   = 8'b0000_0010,
      ST_NONE     = 8'b0000_0100,
      ST_TOUCH    = 8'b0000_1000,
      ST_NXT      = 8'b0001_0000,
      ST_EV3      = 8'b0010_0000,
      ST_I2C      = 8'b0100_0000,
      ST_PIN5_ERR = 8'b1000_0000
   } conn_state_type;

   // Encoded port state as reported on the result channel.
   typedef enum logic [2:0] {
      PS_INIT     = 3'd0,
      PS_SETTLE   = 3'd1,
      PS_NONE     = 3'd2,
      PS_TOUCH    = 3'd3,
      PS_NXT      = 3'd4,
      PS_EV3      = 3'd5,
      PS_I2C      = 3'd6,
      PS_PIN5_ERR = 3'd7
   } port_state_type;

   typedef enum logic [3:0] {
      K_NONE     = 4'd0,
      K_TOUCH    = 4'd1,
      K_LIGHT    = 4'd2,
      K_COLOR    = 4'd3,
      K_DUMB     = 4'd4,
      K_I2C      = 4'd5,
      K_EV3_DUMB = 4'd6,
      K_UART     = 4'd7,
      K_ERR      = 4'd8
   } sensor_kind_type;

   // Register map index (byte address / 4).
   typedef enum logic [2:0] {
      CSR_SETTLE_TICKS   = 3'd0,
      CSR_ADD_TICKS      = 3'd1,
      CSR_REMOVE_TICKS   = 3'd2,
      CSR_NEAR_SUPPLY_MV = 3'd3,
      CSR_NEAR_PIN2_MV   = 3'd4,
      CSR_TOUCH_HIGH_MV  = 3'd5,
      CSR_TOUCH_LOW_MV   = 3'd6,
      CSR_NEAR_GROUND_MV = 3'd7
   } csr_index_type;

   localparam int unsigned TICK_W = 6;
   localparam int unsigned MV_W   = 13;
   localparam int unsigned CNT_W  = 8;

   localparam logic [TICK_W-1:0] SETTLE_TICKS_RST   = 6'd2;
   localparam logic [TICK_W-1:0] ADD_TICKS_RST      = 6'd35;
   localparam logic [TICK_W-1:0] REMOVE_TICKS_RST   = 6'd10;
   localparam logic [MV_W-1:0]   NEAR_SUPPLY_MV_RST = 13'd4800;
   localparam logic [MV_W-1:0]   NEAR_PIN2_MV_RST   = 13'd3100;
   localparam logic [MV_W-1:0]   TOUCH_HIGH_MV_RST  = 13'd950;
   localparam logic [MV_W-1:0]   TOUCH_LOW_MV_RST   = 13'd850;
   localparam logic [MV_W-1:0]   NEAR_GROUND_MV_RST = 13'd100;

   // Allowed pin 1 drift during the touch test (exclusive).
   localparam logic [MV_W:0] TOUCH_VAR_MV = 14'd10;

   // Pin flag bit positions.
   localparam int unsigned F_PIN2_LOW    = 0;
   localparam int unsigned F_PIN1_LOADED = 1;
   localparam int unsigned F_PIN5_LOW    = 2;
   localparam int unsigned F_PIN6_HIGH   = 3;

   function automatic port_state_type state_code(input conn_state_type st);
      port_state_type code;
      case (st)
         ST_INIT:     code = PS_INIT;
         ST_SETTLE:   code = PS_SETTLE;
         ST_NONE:     code = PS_NONE;
         ST_TOUCH:    code = PS_TOUCH;
         ST_NXT:      code = PS_NXT;
         ST_EV3:      code = PS_EV3;
         ST_I2C:      code = PS_I2C;
         ST_PIN5_ERR: code = PS_PIN5_ERR;
         default:     code = PS_INIT;
      endcase
      return code;
   endfunction

endpackage

// ===== sv/sensor_port_connect_detector.sv =====
// Top level of the sensor port connect detector: state machine, CSRs and result register.
//
// Usage: one req_ transaction per poll tick carries the pin 1 voltage (mV), the
// pin 2/5/6 levels and the job_busy / device_registered flags. For every req_
// transaction exactly one rsp_ transaction follows with the port state, the
// detected sensor kind and the register / unregister / float request pulses.
// The result appears in the rsp_ output register in the cycle after the
// req_ transaction is accepted. Throughput: one transaction per cycle while the
// receiver keeps up; the whole tick update is a single pass of compares and next-state logic.
// A new req_ transaction is taken while a result waits, as long as that
// result leaves in the same cycle (req_tready = !rsp_tvalid || rsp_tready);
// when the receiver stalls, the result holds and input is back-pressured.
// Reset: state returns to init, tick counter, pin flags, saved voltage and
// kind clear, CSRs take their default thresholds, rsp_tvalid drops.
// CSRs sit on the csr_ APB port at byte addresses 4*i; write them only while
// no transaction is in flight.
module sensor_port_connect_detector
   import spcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [12:0] pin1_millivolts, [13] pin2_level, [14] pin5_level,
   //            [15] pin6_level, [16] job_busy, [17] device_registered, [23:18] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // rsp_tdata: [2:0] port_state, [6:3] sensor_kind, [7] register_request,
   //            [8] unregister_request, [9] float_request, [15:10] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------------------------------------------------------- CSRs
   logic [TICK_W-1:0] settle_ticks_ff, add_ticks_ff, remove_ticks_ff;
   logic [MV_W-1:0]   near_supply_mv_ff, near_pin2_mv_ff, touch_high_mv_ff;
   logic [MV_W-1:0]   touch_low_mv_ff, near_ground_mv_ff;
   logic              csr_wr;
   csr_index_type     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff   <= SETTLE_TICKS_RST;
         add_ticks_ff      <= ADD_TICKS_RST;
         remove_ticks_ff   <= REMOVE_TICKS_RST;
         near_supply_mv_ff <= NEAR_SUPPLY_MV_RST;
         near_pin2_mv_ff   <= NEAR_PIN2_MV_RST;
         touch_high_mv_ff  <= TOUCH_HIGH_MV_RST;
         touch_low_mv_ff   <= TOUCH_LOW_MV_RST;
         near_ground_mv_ff <= NEAR_GROUND_MV_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_SETTLE_TICKS:   settle_ticks_ff   <= csr_pwdata[TICK_W-1:0];
            CSR_ADD_TICKS:      add_ticks_ff      <= csr_pwdata[TICK_W-1:0];
            CSR_REMOVE_TICKS:   remove_ticks_ff   <= csr_pwdata[TICK_W-1:0];
            CSR_NEAR_SUPPLY_MV: near_supply_mv_ff <= csr_pwdata[MV_W-1:0];
            CSR_NEAR_PIN2_MV:   near_pin2_mv_ff   <= csr_pwdata[MV_W-1:0];
            CSR_TOUCH_HIGH_MV:  touch_high_mv_ff  <= csr_pwdata[MV_W-1:0];
            CSR_TOUCH_LOW_MV:   touch_low_mv_ff   <= csr_pwdata[MV_W-1:0];
            CSR_NEAR_GROUND_MV: near_ground_mv_ff <= csr_pwdata[MV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_SETTLE_TICKS:   csr_prdata = {26'd0, settle_ticks_ff};
         CSR_ADD_TICKS:      csr_prdata = {26'd0, add_ticks_ff};
         CSR_REMOVE_TICKS:   csr_prdata = {26'd0, remove_ticks_ff};
         CSR_NEAR_SUPPLY_MV: csr_prdata = {19'd0, near_supply_mv_ff};
         CSR_NEAR_PIN2_MV:   csr_prdata = {19'd0, near_pin2_mv_ff};
         CSR_TOUCH_HIGH_MV:  csr_prdata = {19'd0, touch_high_mv_ff};
         CSR_TOUCH_LOW_MV:   csr_prdata = {19'd0, touch_low_mv_ff};
         CSR_NEAR_GROUND_MV: csr_prdata = {19'd0, near_ground_mv_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------- handshake
   logic        req_accept;
   logic        rsp_tvalid_ff;
   logic [15:0] rsp_tdata_ff;

   // Output register frees up in the same cycle it is drained.
   assign req_tready = ~rsp_tvalid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ------------------------------------------------------------- fields
   logic [MV_W-1:0] mv;
   logic            pin2_low, pin5_low, pin6_high, busy, registered;

   assign mv         = req_tdata[12:0];
   assign pin2_low   = ~req_tdata[13];
   assign pin5_low   = ~req_tdata[14];
   assign pin6_high  = req_tdata[15];
   assign busy       = req_tdata[16];
   assign registered = req_tdata[17];

   // -------------------------------------------------------------- state
   conn_state_type  conn_state_ff, conn_state_in;
   logic [CNT_W-1:0] tick_count_ff, tick_count_in;
   logic [3:0]       last_pin_flags_ff, last_pin_flags_in;
   logic [MV_W-1:0]  saved_pin1_mv_ff, saved_pin1_mv_in;
   sensor_kind_type  detected_kind_ff, detected_kind_in;

   logic            reg_req, unreg_req, flt_req;
   logic [3:0]      flags;
   logic            testing;
   logic            near_gnd, above_supply, in_touch_band;
   logic [MV_W:0]   mv_plus_var, saved_plus_var;
   logic [CNT_W-1:0] tick_inc;

   always_comb begin
      flags[F_PIN2_LOW]    = pin2_low;
      flags[F_PIN1_LOADED] = mv < near_supply_mv_ff;
      flags[F_PIN5_LOW]    = pin5_low;
      flags[F_PIN6_HIGH]   = pin6_high;
   end

   assign near_gnd       = mv < near_ground_mv_ff;
   assign above_supply   = mv > near_supply_mv_ff;
   assign in_touch_band  = (mv > touch_low_mv_ff) && (mv < touch_high_mv_ff);
   assign mv_plus_var    = {1'b0, mv} + TOUCH_VAR_MV;
   assign saved_plus_var = {1'b0, saved_pin1_mv_ff} + TOUCH_VAR_MV;
   // saturating tick counter, bumped at the start of every tick
   assign tick_inc = (tick_count_ff == {CNT_W{1'b1}}) ? tick_count_ff
                                                       : tick_count_ff + CNT_W'(1);

   always_comb begin
      conn_state_in     = conn_state_ff;
      tick_count_in     = tick_inc;
      last_pin_flags_in = last_pin_flags_ff;
      saved_pin1_mv_in  = saved_pin1_mv_ff;
      detected_kind_in  = detected_kind_ff;
      reg_req           = 1'b0;
      unreg_req         = 1'b0;
      flt_req           = 1'b0;
      testing           = 1'b0;

      case (conn_state_ff)
         ST_SETTLE: begin
            if (tick_inc >= {2'd0, settle_ticks_ff}) begin
               tick_count_in = '0;
               conn_state_in = ST_NONE;
            end
         end
         ST_NONE: begin
            if (flags != last_pin_flags_ff) begin
               tick_count_in = '0;
            end else if (flags != 4'd0 && tick_inc >= {2'd0, add_ticks_ff} && !busy) begin
               if (flags[F_PIN2_LOW]) begin
                  conn_state_in = ST_NXT;
                  if (!flags[F_PIN5_LOW] && flags[F_PIN6_HIGH]) begin
                     detected_kind_in = near_gnd ? K_COLOR : K_I2C;
                  end else if (flags[F_PIN5_LOW]) begin
                     detected_kind_in = flags[F_PIN6_HIGH] ? K_DUMB : K_LIGHT;
                  end else if (near_gnd) begin
                     detected_kind_in = K_COLOR;
                  end else if (above_supply) begin
                     detected_kind_in = K_TOUCH;
                  end else if (in_touch_band) begin
                     // ambiguous band: sample again after the settle time
                     conn_state_in    = ST_TOUCH;
                     saved_pin1_mv_in = mv;
                     testing          = 1'b1;
                  end else begin
                     detected_kind_in = K_DUMB;
                  end
               end else if (flags[F_PIN1_LOADED]) begin
                  conn_state_in = ST_EV3;
                  if (mv > near_pin2_mv_ff)
                     detected_kind_in = K_ERR;
                  else if (near_gnd)
                     detected_kind_in = K_EV3_DUMB;
                  else
                     detected_kind_in = K_UART;
               end else if (flags[F_PIN6_HIGH]) begin
                  conn_state_in    = ST_I2C;
                  detected_kind_in = K_I2C;
               end else begin
                  conn_state_in    = ST_PIN5_ERR;
                  detected_kind_in = K_ERR;
               end
               tick_count_in = '0;
               if (!testing && detected_kind_in != K_ERR && detected_kind_in != K_NONE)
                  reg_req = 1'b1;
            end
            last_pin_flags_in = flags;
         end
         ST_TOUCH: begin
            if (tick_inc >= {2'd0, settle_ticks_ff}) begin
               conn_state_in = ST_NXT;
               // steady pin 1 means a touch sensor
               if (mv_plus_var > {1'b0, saved_pin1_mv_ff} && {1'b0, mv} < saved_plus_var)
                  detected_kind_in = K_TOUCH;
               else
                  detected_kind_in = K_DUMB;
               reg_req = 1'b1;
            end
         end
         // release watch: hold the counter at zero while the pin is still driven
         ST_NXT:      if (pin2_low)  tick_count_in = '0;
         ST_EV3:      if (flags[F_PIN1_LOADED]) tick_count_in = '0;
         ST_I2C:      if (pin6_high) tick_count_in = '0;
         ST_PIN5_ERR: if (pin5_low)  tick_count_in = '0;
         default: begin
            // init: float the port and start over
            flt_req          = 1'b1;
            tick_count_in    = '0;
            detected_kind_in = K_NONE;
            conn_state_in    = ST_SETTLE;
         end
      endcase

      // removal after the release timeout
      if (detected_kind_in != K_NONE && tick_count_in >= {2'd0, remove_ticks_ff} && !busy) begin
         unreg_req     = registered;
         conn_state_in = ST_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_state_ff     <= ST_INIT;
         tick_count_ff     <= '0;
         last_pin_flags_ff <= '0;
         saved_pin1_mv_ff  <= '0;
         detected_kind_ff  <= K_NONE;
      end else if (req_accept) begin
         conn_state_ff     <= conn_state_in;
         tick_count_ff     <= tick_count_in;
         last_pin_flags_ff <= last_pin_flags_in;
         saved_pin1_mv_ff  <= saved_pin1_mv_in;
         detected_kind_ff  <= detected_kind_in;
      end
   end

   // ---------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tdata_ff <= {6'd0, flt_req, unreg_req, reg_req,
                          detected_kind_in, state_code(conn_state_in)};
      end
   end

endmodule

// ===== verif/sensor_port_connect_detector_tb.sv =====
// Self-checking testbench for the sensor port connect detector.
module sensor_port_connect_detector_tb;
   import spcd_pkg::*;

   // Run limits
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 4;     // covers the output register, plus margin
   localparam int HOLD_AT        = 150;   // result count that triggers the long stall
   localparam int HOLD_CYCLES    = 100;
   localparam int TOUCH_DRIFT_MV = 10;    // steady touch test: drift strictly below this
   localparam int MV_MAX         = 8191;

   // One poll tick, packed exactly as on req_tdata (last field in the low bits)
   typedef struct packed {
      logic        device_registered;
      logic        job_busy;
      logic        pin6_level;
      logic        pin5_level;
      logic        pin2_level;
      logic [12:0] pin1_millivolts;
   } poll_tick_type;

   // One tick outcome, packed as on rsp_tdata[9:0]
   typedef struct packed {
      logic            float_request;
      logic            unregister_request;
      logic            register_request;
      sensor_kind_type sensor_kind;
      port_state_type  port_state;
   } port_result_type;

   typedef struct {
      logic [5:0]  settle_ticks;
      logic [5:0]  add_ticks;
      logic [5:0]  remove_ticks;
      logic [12:0] near_supply_mv;
      logic [12:0] near_pin2_mv;
      logic [12:0] touch_high_mv;
      logic [12:0] touch_low_mv;
      logic [12:0] near_ground_mv;
   } detector_cfg_type;

   // DUT ports; every input is known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Stimulus and scoreboard
   poll_tick_type   pending_ticks[$];     // ticks waiting to be offered
   port_result_type expected_results[$];  // outcomes waiting for their rsp_ transaction
   poll_tick_type   tick_on_bus;
   int              mismatches = 0;
   int              cycle_count = 0;
   logic            steady_flow = 1'b0;   // set for the last phase: no idling on either side

   // Driver / receiver bookkeeping
   int unsigned  send_gap = 0;
   int unsigned  stall_left = 0;
   int unsigned  rsp_taken = 0;
   logic         hold_done = 1'b0;

   // Predictor state, mirrors the block's state and CSRs
   detector_cfg_type cfg;
   port_state_type   conn;
   logic [7:0]       ticks;
   logic [3:0]       pin_flags;
   logic [12:0]      saved_mv;
   sensor_kind_type  kind;

   sensor_port_connect_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      // [12:0] pin1_millivolts, [13] pin2_level, [14] pin5_level, [15] pin6_level,
      // [16] job_busy, [17] device_registered, [23:18] zero
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      // [2:0] port_state, [6:3] sensor_kind, [7] register_request,
      // [8] unregister_request, [9] float_request, [15:10] zero
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor: one call per accepted req_ transaction
   // ------------------------------------------------------------------
   function automatic port_result_type predict_tick(input poll_tick_type t);
      port_result_type r;
      logic [3:0]      flags;
      logic [12:0]     mv;
      logic            testing;
      r = '0;
      mv = t.pin1_millivolts;
      testing = 1'b0;
      if (ticks != 8'd255)
         ticks++;

      case (conn)
         PS_INIT: begin
            r.float_request = 1'b1;
            ticks = '0;
            kind = K_NONE;
            conn = PS_SETTLE;
         end
         PS_SETTLE: begin
            if (ticks >= cfg.settle_ticks) begin
               ticks = '0;
               conn = PS_NONE;
            end
         end
         PS_NONE: begin
            flags = '0;
            flags[F_PIN2_LOW]    = !t.pin2_level;
            flags[F_PIN1_LOADED] = mv < cfg.near_supply_mv;
            flags[F_PIN5_LOW]    = !t.pin5_level;
            flags[F_PIN6_HIGH]   = t.pin6_level;
            if (flags != pin_flags) begin
               ticks = '0;
            end else if (flags != '0 && ticks >= cfg.add_ticks && !t.job_busy) begin
               if (flags[F_PIN2_LOW]) begin
                  conn = PS_NXT;
                  if (!flags[F_PIN5_LOW] && flags[F_PIN6_HIGH]) begin
                     if (mv < cfg.near_ground_mv) kind = K_COLOR;
                     else kind = K_I2C;
                  end else if (flags[F_PIN5_LOW]) begin
                     if (flags[F_PIN6_HIGH]) kind = K_DUMB;
                     else kind = K_LIGHT;
                  end else if (mv < cfg.near_ground_mv) begin
                     kind = K_COLOR;
                  end else if (mv > cfg.near_supply_mv) begin
                     kind = K_TOUCH;
                  end else if (mv > cfg.touch_low_mv && mv < cfg.touch_high_mv) begin
                     // ambiguous band: resolve after the touch test
                     conn = PS_TOUCH;
                     saved_mv = mv;
                     testing = 1'b1;
                  end else begin
                     kind = K_DUMB;
                  end
               end else if (flags[F_PIN1_LOADED]) begin
                  conn = PS_EV3;
                  if (mv > cfg.near_pin2_mv) kind = K_ERR;
                  else if (mv < cfg.near_ground_mv) kind = K_EV3_DUMB;
                  else kind = K_UART;
               end else if (flags[F_PIN6_HIGH]) begin
                  conn = PS_I2C;
                  kind = K_I2C;
               end else begin
                  conn = PS_PIN5_ERR;
                  kind = K_ERR;
               end
               ticks = '0;
               if (!testing && kind != K_ERR && kind != K_NONE)
                  r.register_request = 1'b1;
            end
            pin_flags = flags;
         end
         PS_TOUCH: begin
            if (ticks >= cfg.settle_ticks) begin
               conn = PS_NXT;
               if (int'(mv) + TOUCH_DRIFT_MV > int'(saved_mv) &&
                   int'(mv) < int'(saved_mv) + TOUCH_DRIFT_MV)
                  kind = K_TOUCH;
               else
                  kind = K_DUMB;
               r.register_request = 1'b1;
            end
         end
         PS_NXT:  if (!t.pin2_level) ticks = '0;
         PS_EV3:  if (mv < cfg.near_supply_mv) ticks = '0;
         PS_I2C:  if (t.pin6_level) ticks = '0;
         default: if (!t.pin5_level) ticks = '0;
      endcase

      // removal once the sensor pin has been released long enough
      if (kind != K_NONE && ticks >= cfg.remove_ticks && !t.job_busy) begin
         if (t.device_registered)
            r.unregister_request = 1'b1;
         conn = PS_INIT;
      end

      r.port_state  = conn;
      r.sensor_kind = kind;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers pending ticks, predicts each accepted transaction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
         cfg = '{SETTLE_TICKS_RST, ADD_TICKS_RST, REMOVE_TICKS_RST, NEAR_SUPPLY_MV_RST,
                 NEAR_PIN2_MV_RST, TOUCH_HIGH_MV_RST, TOUCH_LOW_MV_RST, NEAR_GROUND_MV_RST};
         conn = PS_INIT;
         ticks = '0;
         pin_flags = '0;
         saved_mv = '0;
         kind = K_NONE;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_tick(tick_on_bus));
         // a transaction still waiting for req_tready stays on the bus untouched
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_ticks.size() != 0 && !steady_flow &&
                         $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 12) - 1;
               req_tvalid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               tick_on_bus = pending_ticks.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, tick_on_bus};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold to back up the input
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            rsp_taken++;
         if (!hold_done && rsp_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each rsp_ transaction with the oldest expectation
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_monitor
      port_result_type got;
      port_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = port_result_type'(rsp_tdata[9:0]);
         if (expected_results.size() == 0) begin
            $error("rsp_ transaction with no tick outstanding: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("port_state", 4'(want.port_state), 4'(got.port_state));
            check_field("sensor_kind", want.sensor_kind, got.sensor_kind);
            check_field("register_request", 4'(want.register_request),
                        4'(got.register_request));
            check_field("unregister_request", 4'(want.unregister_request),
                        4'(got.unregister_request));
            check_field("float_request", 4'(want.float_request), 4'(got.float_request));
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic poll_tick_type make_tick(input logic [12:0] mv, input logic pin2,
                                               input logic pin5, input logic pin6,
                                               input logic busy, input logic registered);
      poll_tick_type t;
      t.pin1_millivolts   = mv;
      t.pin2_level        = pin2;
      t.pin5_level        = pin5;
      t.pin6_level        = pin6;
      t.job_busy          = busy;
      t.device_registered = registered;
      return t;
   endfunction

   task automatic push_ticks(input poll_tick_type t, input int n);
      repeat (n) pending_ticks.push_back(t);
   endtask

   // pin 1 voltage near the thresholds in force, or anywhere
   function automatic logic [12:0] pick_mv();
      int cand[15];
      int v;
      cand = '{0, MV_MAX,
               int'(cfg.near_ground_mv) - 1, int'(cfg.near_ground_mv),
               int'(cfg.near_ground_mv) + 1,
               int'(cfg.touch_low_mv), int'(cfg.touch_low_mv) + 1,
               (int'(cfg.touch_low_mv) + int'(cfg.touch_high_mv)) / 2,
               int'(cfg.touch_high_mv) - 1, int'(cfg.touch_high_mv),
               int'(cfg.near_pin2_mv), int'(cfg.near_pin2_mv) + 1,
               int'(cfg.near_supply_mv) - 1, int'(cfg.near_supply_mv),
               int'(cfg.near_supply_mv) + 1};
      if ($urandom_range(0, 3) == 0) v = $urandom_range(0, MV_MAX);
      else v = cand[$urandom_range(0, 14)];
      if (v < 0) v = 0;
      else if (v > MV_MAX) v = MV_MAX;
      return v[12:0];
   endfunction

   // plug a sensor, hold it (sometimes too briefly), then pull it
   task automatic plan_session();
      poll_tick_type t;
      logic [12:0]   base_mv;
      logic          registered;
      logic          jitter;
      int            hold;
      int            release_len;
      int            v;
      base_mv = pick_mv();
      registered = 1'($urandom_range(0, 1));
      jitter = ($urandom_range(0, 3) == 0);
      t = make_tick(base_mv, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0, registered);
      if ($urandom_range(0, 7) == 0)
         hold = $urandom_range(1, int'(cfg.add_ticks) + 2);
      else
         hold = 2 * int'(cfg.settle_ticks) + int'(cfg.add_ticks) + $urandom_range(3, 30);
      repeat (hold) begin
         t.job_busy = ($urandom_range(0, 11) == 0);
         t.device_registered = ($urandom_range(0, 15) == 0) ? !registered : registered;
         if (jitter) begin
            // drift decides between touch and dumb at the end of a touch test
            v = int'(base_mv) + int'($urandom_range(0, 24)) - 12;
            if (v < 0) v = 0;
            else if (v > MV_MAX) v = MV_MAX;
            t.pin1_millivolts = v[12:0];
         end
         pending_ticks.push_back(t);
      end
      // released port: pin 2 and 5 high, pin 6 low, pin 1 unloaded
      release_len = int'(cfg.remove_ticks) + int'(cfg.settle_ticks) + $urandom_range(2, 12);
      repeat (release_len)
         pending_ticks.push_back(make_tick(13'($urandom_range(cfg.near_supply_mv, MV_MAX)),
                                           1'b1, 1'b1, 1'b0, $urandom_range(0, 11) == 0,
                                           1'($urandom_range(0, 1))));
   endtask

   // mostly well-formed sessions, some raw noise
   task automatic plan_random(input int budget);
      int goal;
      goal = pending_ticks.size() + budget;
      while (pending_ticks.size() < goal) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 20))
               pending_ticks.push_back(make_tick(13'($urandom_range(0, MV_MAX)),
                                                 1'($urandom_range(0, 1)),
                                                 1'($urandom_range(0, 1)),
                                                 1'($urandom_range(0, 1)),
                                                 1'($urandom_range(0, 1)),
                                                 1'($urandom_range(0, 1))));
         else
            plan_session();
      end
   endtask

   function automatic detector_cfg_type random_settings();
      detector_cfg_type c;
      c.settle_ticks   = 6'($urandom_range(0, 8));
      c.add_ticks      = 6'($urandom_range(0, 12));
      c.remove_ticks   = 6'($urandom_range(0, 12));
      c.near_supply_mv = 13'($urandom_range(0, MV_MAX));
      c.near_pin2_mv   = 13'($urandom_range(0, MV_MAX));
      c.touch_high_mv  = 13'($urandom_range(0, MV_MAX));
      c.touch_low_mv   = 13'($urandom_range(0, MV_MAX));
      c.near_ground_mv = 13'($urandom_range(0, MV_MAX));
      return c;
   endfunction

   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // only called with nothing in flight; the predictor takes the new set after
   task automatic apply_settings(input detector_cfg_type c);
      csr_write(CSR_SETTLE_TICKS,   32'(c.settle_ticks));
      csr_write(CSR_ADD_TICKS,      32'(c.add_ticks));
      csr_write(CSR_REMOVE_TICKS,   32'(c.remove_ticks));
      csr_write(CSR_NEAR_SUPPLY_MV, 32'(c.near_supply_mv));
      csr_write(CSR_NEAR_PIN2_MV,   32'(c.near_pin2_mv));
      csr_write(CSR_TOUCH_HIGH_MV,  32'(c.touch_high_mv));
      csr_write(CSR_TOUCH_LOW_MV,   32'(c.touch_low_mv));
      csr_write(CSR_NEAR_GROUND_MV, 32'(c.near_ground_mv));
      cfg = c;
      @(negedge clock);
   endtask

   // sender pause: every tick sent, every result back, then a few quiet cycles
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero tick counts so each case classifies within a few ticks.
      // Each block walks init, settle, a flag change, then classification and
      // immediate removal.
      apply_settings('{6'd0, 6'd0, 6'd0, 13'd4800, 13'd3100, 13'd950, 13'd850, 13'd100});
      // pin 1 above the supply threshold with pin 2 low: touch
      push_ticks(make_tick(13'd8191, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0), 4);
      // pin 1 in the ambiguous band: touch test, steady voltage, register on resolve
      push_ticks(make_tick(13'd900, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1), 5);
      // loaded pin 1 at ground: ev3 dumb, unregister since a device is registered
      push_ticks(make_tick(13'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1), 4);
      // loaded pin 1 above the pin 2 threshold: error kind, no register request
      push_ticks(make_tick(13'd4000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0), 4);
      // pin 5 low alone: pin 5 error
      push_ticks(make_tick(13'd8191, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1), 4);
      // pin 6 high alone, classification held back by a busy job
      push_ticks(make_tick(13'd8191, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1), 4);
      push_ticks(make_tick(13'd8191, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1), 2);
      wait_drained();

      // Reset thresholds; a long empty-port stretch saturates the tick counter
      apply_settings('{6'd2, 6'd35, 6'd10, 13'd4800, 13'd3100, 13'd950, 13'd850, 13'd100});
      plan_random(300);
      push_ticks(make_tick(13'd8191, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0), 300);
      wait_drained();

      // Upper extremes: longest waits, thresholds at full scale but touch low at zero
      apply_settings('{6'd63, 6'd63, 6'd63, 13'd8191, 13'd8191, 13'd8191, 13'd0, 13'd8191});
      plan_random(250);
      wait_drained();

      // Lower extremes: nothing counts as loaded or grounded
      apply_settings('{6'd1, 6'd3, 6'd2, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0});
      plan_random(150);
      wait_drained();

      repeat (2) begin
         apply_settings(random_settings());
         plan_random(200);
         wait_drained();
      end

      // Last part: back-to-back transactions, no idling on either side
      steady_flow = 1'b1;
      apply_settings('{6'd1, 6'd4, 6'd3, 13'd4800, 13'd3100, 13'd950, 13'd850, 13'd100});
      plan_random(200);
      wait_drained();

      if (mismatches == 0 && expected_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

endmodule
